@@ rtl/apr_pkg.sv @@
// Package with shared constants, types and the CRC helper for the auth page report framer.
package apr_pkg;

    localparam int PAGE_BYTES_DEF          = 56;
    localparam int NONCE_PAGE_COUNT_DEF    = 5;
    localparam int RESPONSE_PAGE_COUNT_DEF = 19;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [7:0]  PFX_STATUS = 8'hF2;
    localparam logic [7:0]  PFX_PAGE   = 8'hF1;
    localparam logic [7:0]  STAT_NOT_READY = 8'h10;

    localparam int STATUS_BODY = 11;

    typedef enum logic [2:0] {
        OP_NONCE    = 3'd0,
        OP_DISPATCH = 3'd1,
        OP_SNAP_RD  = 3'd2,
        OP_RESP_WR  = 3'd3,
        OP_SIGN_DONE= 3'd4,
        OP_STATUS   = 3'd5,
        OP_PAGE     = 3'd6,
        OP_RESET    = 3'd7
    } op_t;

    // One byte of the reflected CRC-32, eight bit steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

@@ rtl/auth_page_report_framer_unit.sv @@
// Top level of the auth page report framer: control sequencer, stores and report framing.
//
// One transaction is handled at a time. A nonce byte, dispatch request, response write,
// sign done or reset op presents its one result in the cycle after acceptance; the next
// transaction is taken only once that result is accepted and the sequencer is back in idle.
// A snapshot read passes through ST_SNAP, which takes the registered snapshot read data,
// before its byte is presented. A report sends its body and then four CRC bytes, one byte
// per cycle while the receiver does not stall, updating the CRC on every body byte.
// Whole-store operations walk memory one entry a cycle: a session start clears the nonce
// store, a dispatch copies nonce to snapshot and a failed sign done clears the response
// store. After reset, and after a reset op, all three memories are cleared in one pass of
// max(nonce, response) size, during which no input transaction is accepted; configuration
// writes are taken at all times.
module auth_page_report_framer_unit
    import apr_pkg::*;
#(
    parameter int PAGE_BYTES          = PAGE_BYTES_DEF,
    parameter int NONCE_PAGE_COUNT    = NONCE_PAGE_COUNT_DEF,
    parameter int RESPONSE_PAGE_COUNT = RESPONSE_PAGE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], session_id[10:3], page_number[18:11], index[29:19], value[37:30],
    // page_first[38], data_present[39], sign_ok[40], zero fill[47:41]
    input  logic [47:0] s_tdata,
    // page_last
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte[7:0], sign_start[8], signing_busy[9], sig_ready[10], zero fill[15:11]
    output logic [15:0] m_tdata,
    // run_last
    output logic        m_tlast
);

    localparam int NONCE_BYTES = PAGE_BYTES * NONCE_PAGE_COUNT;
    localparam int RESP_BYTES  = PAGE_BYTES * RESPONSE_PAGE_COUNT;
    localparam int CLR_BYTES   = (NONCE_BYTES > RESP_BYTES) ? NONCE_BYTES : RESP_BYTES;
    localparam int NAW = $clog2(NONCE_BYTES);
    localparam int RAW = $clog2(RESP_BYTES);
    localparam int CAW = $clog2(CLR_BYTES + 1);
    localparam int PCW = $clog2(NONCE_PAGE_COUNT + 1);
    localparam int CUW = $clog2(RESPONSE_PAGE_COUNT + 1);
    localparam int BW  = $clog2(PAGE_BYTES + 8);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_NCLR, ST_COPY, ST_RCLR, ST_SNAP, ST_RPT, ST_CRC, ST_OUT1
    } state_t;

    // Input field unpack.
    op_t         in_op;
    logic [7:0]  in_sid, in_pg, in_val;
    logic [10:0] in_idx;
    logic        in_first, in_present, in_ok;
    assign in_op      = op_t'(s_tdata[2:0]);
    assign in_sid     = s_tdata[10:3];
    assign in_pg      = s_tdata[18:11];
    assign in_idx     = s_tdata[29:19];
    assign in_val     = s_tdata[37:30];
    assign in_first   = s_tdata[38];
    assign in_present = s_tdata[39];
    assign in_ok      = s_tdata[40];

    state_t            state_reg;
    logic              en_reg;
    logic [7:0]        sess_reg;
    logic [PCW-1:0]    seen_reg;
    logic              pend_reg, busy_reg, ready_reg;
    logic [CUW-1:0]    cur_reg;
    logic [31:0]       crc_reg;
    logic [CAW-1:0]    cnt_reg;
    logic [BW-1:0]     k_reg;
    logic [BW-1:0]     n_reg;
    logic              kind_page_reg;
    logic [7:0]        pnum_reg;
    logic [RAW-1:0]    pbase_reg;
    logic              copy_wr_reg;
    logic [NAW-1:0]    copy_addr_reg;
    logic              snap_oob_reg;
    logic [1:0]        cb_reg;
    logic              mvalid_reg;
    logic [7:0]        mbyte_reg;
    logic              mlast_reg, mstart_reg;
    // Pending nonce write, performed in idle after any session clear.
    logic              nw_reg;
    logic [NAW-1:0]    nw_addr_reg;
    logic [7:0]        nw_val_reg;

    // Memory ports.
    logic           n_we, s_we, r_we;
    logic [NAW-1:0] n_waddr, n_raddr, s_waddr, s_raddr;
    logic [RAW-1:0] r_waddr, r_raddr;
    logic [7:0]     n_wdata, s_wdata, r_wdata, n_rdata, s_rdata, r_rdata;

    apr_ram #(.WIDTH(8), .DEPTH(NONCE_BYTES)) u_nonce (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata));
    apr_ram #(.WIDTH(8), .DEPTH(NONCE_BYTES)) u_snap (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata));
    apr_ram #(.WIDTH(8), .DEPTH(RESP_BYTES)) u_resp (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata));

    logic acc, out_free, m_acc;
    assign s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign acc      = s_tvalid && s_tready;
    assign m_acc    = mvalid_reg && m_tready;
    assign out_free = !mvalid_reg || m_tready;

    // Report body position k: bytes 0..2 header, then memory bytes for a page report.
    logic [RAW-1:0] rd_off;
    assign rd_off = pbase_reg + RAW'(k_reg) - RAW'(3);

    // Byte of the report body at position k_reg (memory read data is already that of position k_reg).
    logic [7:0] body_byte;
    always_comb
    begin
        if (k_reg == BW'(0))
        begin
            body_byte = sess_reg;
        end
        else if (k_reg == BW'(1))
        begin
            body_byte = kind_page_reg ? pnum_reg : (ready_reg ? 8'h00 : STAT_NOT_READY);
        end
        else if (!kind_page_reg || k_reg == BW'(2))
        begin
            body_byte = 8'h00;
        end
        else
        begin
            body_byte = r_rdata;
        end
    end

    // Memory port control. The response read runs one position ahead while the
    // output moves and holds the current position while it is stalled.
    always_comb
    begin
        n_we = 1'b0; n_waddr = nw_addr_reg; n_wdata = nw_val_reg;
        s_we = 1'b0; s_waddr = copy_addr_reg; s_wdata = n_rdata;
        r_we = 1'b0; r_waddr = in_idx[RAW-1:0]; r_wdata = in_val;
        n_raddr = cnt_reg[NAW-1:0];
        s_raddr = in_idx[NAW-1:0];
        r_raddr = rd_off + RAW'(out_free);
        case (state_reg)
            ST_CLEAR:
            begin
                n_we = (cnt_reg < CAW'(NONCE_BYTES)); n_waddr = cnt_reg[NAW-1:0];
                n_wdata = 8'h00;
                s_we = n_we; s_waddr = cnt_reg[NAW-1:0]; s_wdata = 8'h00;
                r_we = (cnt_reg < CAW'(RESP_BYTES)); r_waddr = cnt_reg[RAW-1:0];
                r_wdata = 8'h00;
            end
            ST_NCLR:
            begin
                n_we = 1'b1; n_waddr = cnt_reg[NAW-1:0]; n_wdata = 8'h00;
            end
            ST_COPY:
            begin
                s_we = copy_wr_reg;
            end
            ST_RCLR:
            begin
                r_we = 1'b1; r_waddr = cnt_reg[RAW-1:0]; r_wdata = 8'h00;
            end
            ST_IDLE:
            begin
                n_we = nw_reg;
                r_we = acc && (in_op == OP_RESP_WR) && en_reg &&
                       (in_idx < 11'(RESP_BYTES));
            end
            default:
            begin
            end
        endcase
    end

    logic [7:0] crc_out;
    always_comb
    begin
        case (cb_reg)
            2'd0:    crc_out = ~crc_reg[7:0];
            2'd1:    crc_out = ~crc_reg[15:8];
            2'd2:    crc_out = ~crc_reg[23:16];
            default: crc_out = ~crc_reg[31:24];
        endcase
    end

    // Sequencer with all control and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR; en_reg <= 1'b0; sess_reg <= 8'd0; seen_reg <= '0;
            pend_reg <= 1'b0; busy_reg <= 1'b0; ready_reg <= 1'b0; cur_reg <= '0;
            crc_reg <= CRC_INIT; cnt_reg <= '0; k_reg <= '0; n_reg <= '0;
            kind_page_reg <= 1'b0; pnum_reg <= 8'd0; pbase_reg <= '0; copy_wr_reg <= 1'b0;
            copy_addr_reg <= '0; snap_oob_reg <= 1'b0; cb_reg <= 2'd0; mvalid_reg <= 1'b0;
            mbyte_reg <= 8'd0; mlast_reg <= 1'b0; mstart_reg <= 1'b0; nw_reg <= 1'b0;
            nw_addr_reg <= '0; nw_val_reg <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                en_reg <= cfg_wdata;
            end
            if (m_acc)
            begin
                mvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    if (cnt_reg == CAW'(CLR_BYTES - 1))
                    begin
                        cnt_reg <= '0; state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CAW'(1);
                    end
                end
                ST_NCLR:
                begin
                    if (cnt_reg == CAW'(NONCE_BYTES - 1))
                    begin
                        cnt_reg <= '0; state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CAW'(1);
                    end
                end
                ST_RCLR:
                begin
                    if (cnt_reg == CAW'(RESP_BYTES - 1))
                    begin
                        cnt_reg <= '0; state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CAW'(1);
                    end
                end
                ST_COPY:
                begin
                    copy_wr_reg <= (cnt_reg < CAW'(NONCE_BYTES));
                    copy_addr_reg <= cnt_reg[NAW-1:0];
                    if (cnt_reg == CAW'(NONCE_BYTES))
                    begin
                        cnt_reg <= '0; state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CAW'(1);
                    end
                end
                ST_SNAP:
                begin
                    if (out_free)
                    begin
                        mvalid_reg <= 1'b1; mlast_reg <= 1'b1; mstart_reg <= 1'b0;
                        mbyte_reg <= snap_oob_reg ? 8'h00 : s_rdata;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT1:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_RPT:
                begin
                    // k_reg is the body position whose byte is ready this cycle.
                    if (out_free)
                    begin
                        mvalid_reg <= 1'b1; mlast_reg <= 1'b0; mstart_reg <= 1'b0;
                        mbyte_reg <= body_byte;
                        crc_reg <= crc_byte(crc_reg, body_byte);
                        if (k_reg == n_reg - BW'(1))
                        begin
                            cb_reg <= 2'd0; state_reg <= ST_CRC;
                        end
                        else
                        begin
                            k_reg <= k_reg + BW'(1);
                        end
                    end
                end
                ST_CRC:
                begin
                    if (out_free)
                    begin
                        mvalid_reg <= 1'b1; mbyte_reg <= crc_out;
                        mlast_reg <= (cb_reg == 2'd3); mstart_reg <= 1'b0;
                        cb_reg <= cb_reg + 2'd1;
                        if (cb_reg == 2'd3)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    nw_reg <= 1'b0;
                    if (acc)
                    begin
                        mbyte_reg <= 8'h00; mlast_reg <= 1'b1; mstart_reg <= 1'b0;
                        case (in_op)
                            OP_NONCE:
                            begin
                                mvalid_reg <= 1'b1;
                                if (en_reg && in_pg < 8'(NONCE_PAGE_COUNT))
                                begin
                                    nw_reg <= in_present && (in_idx < 11'(PAGE_BYTES));
                                    nw_addr_reg <= NAW'(in_pg * PAGE_BYTES)
                                                   + NAW'(in_idx);
                                    nw_val_reg <= in_val;
                                    if (in_first && in_pg == 8'd0)
                                    begin
                                        sess_reg <= in_sid; ready_reg <= 1'b0;
                                        cur_reg <= '0; cnt_reg <= '0;
                                        state_reg <= ST_NCLR;
                                        pend_reg <= s_tlast && (NONCE_PAGE_COUNT == 1);
                                        seen_reg <= s_tlast ? PCW'(1) : '0;
                                    end
                                    else if (s_tlast)
                                    begin
                                        if (seen_reg < PCW'(NONCE_PAGE_COUNT))
                                        begin
                                            seen_reg <= seen_reg + PCW'(1);
                                        end
                                        if (seen_reg >= PCW'(NONCE_PAGE_COUNT - 1))
                                        begin
                                            pend_reg <= 1'b1;
                                        end
                                    end
                                end
                            end
                            OP_DISPATCH:
                            begin
                                mvalid_reg <= 1'b1;
                                if (en_reg && !busy_reg && !ready_reg && pend_reg)
                                begin
                                    pend_reg <= 1'b0; cur_reg <= '0; busy_reg <= 1'b1;
                                    mstart_reg <= 1'b1; cnt_reg <= '0;
                                    copy_wr_reg <= 1'b0; state_reg <= ST_COPY;
                                end
                            end
                            OP_SNAP_RD:
                            begin
                                snap_oob_reg <= (in_idx >= 11'(NONCE_BYTES));
                                state_reg <= ST_SNAP;
                            end
                            OP_RESP_WR:
                            begin
                                mvalid_reg <= 1'b1;
                            end
                            OP_SIGN_DONE:
                            begin
                                mvalid_reg <= 1'b1;
                                if (en_reg && busy_reg)
                                begin
                                    cur_reg <= '0; ready_reg <= 1'b1; busy_reg <= 1'b0;
                                    if (!in_ok)
                                    begin
                                        cnt_reg <= '0; state_reg <= ST_RCLR;
                                    end
                                end
                            end
                            OP_STATUS:
                            begin
                                kind_page_reg <= 1'b0; k_reg <= '0;
                                n_reg <= BW'(STATUS_BODY);
                                crc_reg <= crc_byte(CRC_INIT, PFX_STATUS);
                                state_reg <= ST_RPT;
                            end
                            OP_PAGE:
                            begin
                                kind_page_reg <= 1'b1; k_reg <= '0;
                                n_reg <= BW'(PAGE_BYTES + 3);
                                crc_reg <= crc_byte(CRC_INIT, PFX_PAGE);
                                if (cur_reg < CUW'(RESPONSE_PAGE_COUNT))
                                begin
                                    pnum_reg <= 8'(cur_reg);
                                    pbase_reg <= RAW'(cur_reg * PAGE_BYTES);
                                    cur_reg <= cur_reg + CUW'(1);
                                end
                                else
                                begin
                                    pnum_reg <= 8'(RESPONSE_PAGE_COUNT - 1);
                                    pbase_reg <= RAW'((RESPONSE_PAGE_COUNT - 1) * PAGE_BYTES);
                                end
                                state_reg <= ST_RPT;
                            end
                            default:
                            begin
                                mvalid_reg <= 1'b1;
                                sess_reg <= 8'd0; seen_reg <= '0; pend_reg <= 1'b0;
                                busy_reg <= 1'b0; ready_reg <= 1'b0; cur_reg <= '0;
                                crc_reg <= CRC_INIT; cnt_reg <= '0; state_reg <= ST_CLEAR;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // Status flags shown with a result reflect the state after the transaction.
    assign m_tvalid = mvalid_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {5'd0, ready_reg, busy_reg && !ready_reg, mstart_reg, mbyte_reg};

`ifndef SYNTHESIS
    a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept outside idle");
    a_busy_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && ready_reg)) else $error("busy and ready together");
    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (mvalid_reg && mstart_reg) |-> busy_reg) else $error("start without busy");
    a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= PCW'(NONCE_PAGE_COUNT)) else $error("pages seen overflow");
`endif

endmodule

@@ rtl/apr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module apr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
